// ===== rtl/ata_pkg.sv =====
// shared types, constants and arctangent table for the tilt angle pipeline
`default_nettype none

package ata_pkg;

  // field and bus widths
  localparam int AXIS_W     = 16;
  localparam int ROLL_W     = 17;
  localparam int PITCH_W    = 16;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 40;

  // defaults for the top level parameters
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;

  // angle accumulator: degrees with 24 fraction bits
  localparam int ANG_FRAC = 24;
  localparam int ANG_W    = 32;
  localparam logic [ANG_W-1:0] ANG90  = 32'd1509949440;
  localparam logic [ANG_W-1:0] ANG180 = 32'd3019898880;

  // cordic vector width, enough for the gain on a 2^32 input
  localparam int VEC_W = 36;

  // square root of (y*y + z*z) << 16, one result bit per cell
  localparam int SUM_W      = 32;
  localparam int SQRT_STEPS = 24;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 2;

  // round(atan(2^-i) * 180/pi * 2^24)
  localparam int TAB_LEN = 24;
  localparam logic [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  // operand cases that bypass the cordic result
  typedef enum logic [1:0] {
    SPC_NONE,
    SPC_ZERO,
    SPC_RIGHT
  } spc_t;

  typedef struct packed {
    logic [AXIS_W-1:0] mag_x;
    logic [AXIS_W-1:0] mag_y;
    logic [AXIS_W-1:0] mag_z;
    logic              x_pos;
    logic              y_neg;
    logic              z_neg;
  } samp_t;

  typedef struct packed {
    samp_t             s;
    logic [SUM_W-1:0]  sumsq;
  } prep_t;

  typedef struct packed {
    samp_t              s;
    logic [RAD_W-1:0]   rad;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
  } sqrt_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] xv;
    logic signed [VEC_W-1:0] yv;
    logic signed [ANG_W-1:0] ang;
    spc_t                    spc;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    logic  x_pos;
    logic  y_neg;
    logic  z_neg;
  } cord_t;

  typedef struct packed {
    logic [ANG_W-1:0] roll_mag;
    logic [ANG_W-1:0] pitch_mag;
    logic             roll_neg;
    logic             pitch_neg;
  } fold_t;

endpackage

`default_nettype wire

// ===== rtl/ata_prep.sv =====
// input stage: axis magnitudes, signs and the sum of squares
`default_nettype none

module ata_prep (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [ata_pkg::AXIS_W-1:0]     in_x,
  input  wire  [ata_pkg::AXIS_W-1:0]     in_y,
  input  wire  [ata_pkg::AXIS_W-1:0]     in_z,
  output logic                           out_valid,
  input  wire                            out_ready,
  output ata_pkg::prep_t                 out_data
);
  import ata_pkg::*;

  prep_t data_next;
  logic signed [2*AXIS_W-1:0] ysq;
  logic signed [2*AXIS_W-1:0] zsq;

  function automatic logic [AXIS_W-1:0] mag(input logic [AXIS_W-1:0] v);
    return v[AXIS_W-1] ? AXIS_W'(-v) : v;
  endfunction

  always_comb begin
    ysq = $signed(in_y) * $signed(in_y);
    zsq = $signed(in_z) * $signed(in_z);
    data_next.s.mag_x = mag(in_x);
    data_next.s.mag_y = mag(in_y);
    data_next.s.mag_z = mag(in_z);
    // pitch numerator is -x, so it is negative when x is positive
    data_next.s.x_pos = !in_x[AXIS_W-1] && (in_x != '0);
    data_next.s.y_neg = in_y[AXIS_W-1];
    data_next.s.z_neg = in_z[AXIS_W-1];
    data_next.sumsq   = SUM_W'(ysq) + SUM_W'(zsq);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ata_sqrt_cell.sv =====
// one digit step of the integer square root, carrying the sample along
`default_nettype none

module ata_sqrt_cell (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  ata_pkg::sqrt_t  in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output ata_pkg::sqrt_t  out_data
);
  import ata_pkg::*;

  sqrt_t data_next;
  logic [REM_W+1:0] cur;
  logic [REM_W+1:0] trial;

  always_comb begin
    cur   = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
    trial = {2'b00, in_data.root, 2'b01};
    data_next.s   = in_data.s;
    data_next.rad = {in_data.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      data_next.rem  = REM_W'(cur - trial);
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_next.rem  = cur[REM_W-1:0];
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ata_cordic_cell.sv =====
// one vectoring cordic rotation for the roll and pitch lanes
`default_nettype none

module ata_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  ata_pkg::cord_t  in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output ata_pkg::cord_t  out_data
);
  import ata_pkg::*;

  cord_t data_next;

  function automatic lane_t rot(input lane_t l);
    lane_t r;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    dx = $signed(l.yv) >>> STAGE;
    dy = $signed(l.xv) >>> STAGE;
    r  = l;
    if (!l.yv[VEC_W-1]) begin
      r.xv  = l.xv + dx;
      r.yv  = l.yv - dy;
      r.ang = l.ang + $signed(ATAN_TAB[STAGE]);
    end else begin
      r.xv  = l.xv - dx;
      r.yv  = l.yv + dy;
      r.ang = l.ang - $signed(ATAN_TAB[STAGE]);
    end
    return r;
  endfunction

  always_comb begin
    data_next       = in_data;
    data_next.roll  = rot(in_data.roll);
    data_next.pitch = rot(in_data.pitch);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ata_finish.sv =====
// quadrant fold, rounding, saturation and sign; holds the output register
`default_nettype none

module ata_finish #(
  parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  ata_pkg::cord_t                in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [ata_pkg::ROLL_W-1:0]    roll_deg,
  output logic [ata_pkg::PITCH_W-1:0]   pitch_deg
);
  import ata_pkg::*;

  localparam int SHIFT = ANG_FRAC - ANGLE_FRAC_BITS;
  localparam logic [ANG_W:0] HALF = (ANG_W+1)'(1) << (SHIFT - 1);
  localparam logic [ANG_W:0] ROLL_LIM  = (ANG_W+1)'((1 << (ROLL_W - 1)) - 1);
  localparam logic [ANG_W:0] PITCH_LIM = (ANG_W+1)'((1 << (PITCH_W - 1)) - 1);

  fold_t fold_next;
  fold_t fold;
  logic  fold_valid;
  logic  fold_ready;
  logic [ANG_W-1:0] roll_q1;
  logic [ANG_W-1:0] pitch_q1;
  logic [ANG_W:0]   roll_rnd;
  logic [ANG_W:0]   pitch_rnd;
  logic [ROLL_W-1:0]  roll_sat;
  logic [PITCH_W-1:0] pitch_sat;
  logic [ROLL_W-1:0]  roll_next;
  logic [PITCH_W-1:0] pitch_next;

  function automatic logic [ANG_W-1:0] q1(input lane_t l);
    logic [ANG_W-1:0] a;
    unique case (l.spc)
      SPC_ZERO:  a = '0;
      SPC_RIGHT: a = ANG90;
      default: begin
        if (l.ang[ANG_W-1]) begin
          a = '0;
        end else if (l.ang > $signed(ANG90)) begin
          a = ANG90;
        end else begin
          a = l.ang;
        end
      end
    endcase
    return a;
  endfunction

  // first register: first-quadrant angle, roll folded into the left half-plane
  always_comb begin
    roll_q1  = q1(in_data.roll);
    pitch_q1 = q1(in_data.pitch);
    fold_next.roll_mag  = in_data.z_neg ? ANG180 - roll_q1 : roll_q1;
    fold_next.pitch_mag = pitch_q1;
    fold_next.roll_neg  = in_data.y_neg;
    fold_next.pitch_neg = in_data.x_pos;
  end

  assign in_ready = !fold_valid || fold_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_valid <= 1'b0;
    end else if (in_ready) begin
      fold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fold <= fold_next;
    end
  end

  // second register: round half up, saturate, apply sign
  always_comb begin
    roll_rnd  = ({1'b0, fold.roll_mag} + HALF) >> SHIFT;
    pitch_rnd = ({1'b0, fold.pitch_mag} + HALF) >> SHIFT;
    roll_sat  = (roll_rnd > ROLL_LIM) ? ROLL_W'(ROLL_LIM) : roll_rnd[ROLL_W-1:0];
    pitch_sat = (pitch_rnd > PITCH_LIM) ? PITCH_W'(PITCH_LIM) : pitch_rnd[PITCH_W-1:0];
    roll_next  = fold.roll_neg ? ROLL_W'(-roll_sat) : roll_sat;
    pitch_next = fold.pitch_neg ? PITCH_W'(-pitch_sat) : pitch_sat;
  end

  assign fold_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fold_ready) begin
      out_valid <= fold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fold_ready && fold_valid) begin
      roll_deg  <= roll_next;
      pitch_deg <= pitch_next;
    end
  end

  a_roll_mag_range: assert property (@(posedge clk) disable iff (rst)
    fold_valid |-> fold.roll_mag <= ANG180)
    else $error("roll magnitude beyond half turn");

  a_pitch_mag_range: assert property (@(posedge clk) disable iff (rst)
    fold_valid |-> fold.pitch_mag <= ANG90)
    else $error("pitch magnitude beyond right angle");

  a_out_advance: assert property (@(posedge clk) disable iff (rst)
    fold_valid && fold_ready |=> out_valid)
    else $error("folded beat lost before output register");

endmodule

`default_nettype wire

// ===== rtl/accel_tilt_angles.sv =====
// top level: roll and pitch from a three-axis accelerometer sample
//
// s_* carries one sample per beat (x, y, z signed 16 bit); m_* returns one
// beat per sample with roll = atan2(y, z) and pitch = atan2(-x, |(y, z)|) in
// degrees, signed, ANGLE_FRAC_BITS fraction bits. Results keep input order.
// The pipeline holds the squares register, 24 square-root digit cells, one
// cordic cell per stage, and the fold register followed by the rounding and
// output register. While m_tready is high the chain of cells takes a new
// sample every cycle, so sustained throughput is one beat per cycle.
// Each cell has its own valid bit; when m_tready is low the last result waits
// in the output register and beats close up behind it, so s_tready drops only
// once every cell holds a beat. Reset clears the valid bits only; there is no
// state carried from one sample to the next.
`default_nettype none

module accel_tilt_angles #(
  parameter int CORDIC_STAGES   = ata_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [ata_pkg::S_TDATA_W-1:0]     s_tdata,   // accel_x, accel_y, accel_z
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [ata_pkg::M_TDATA_W-1:0]     m_tdata    // roll_deg, pitch_deg, zero pad
);
  import ata_pkg::*;

  localparam int ROLL_MAX_RAW  = 180 << ANGLE_FRAC_BITS;
  localparam int PITCH_MAX_RAW = 90 << ANGLE_FRAC_BITS;
  localparam int ROLL_MAX  = (ROLL_MAX_RAW > (1 << (ROLL_W - 1)) - 1) ?
                             (1 << (ROLL_W - 1)) - 1 : ROLL_MAX_RAW;
  localparam int PITCH_MAX = (PITCH_MAX_RAW > (1 << (PITCH_W - 1)) - 1) ?
                             (1 << (PITCH_W - 1)) - 1 : PITCH_MAX_RAW;

  prep_t prep_data;
  sqrt_t sq_d   [SQRT_STEPS+1];
  logic  sq_v   [SQRT_STEPS+1];
  logic  sq_rdy [SQRT_STEPS+1];
  cord_t cd_d   [CORDIC_STAGES+1];
  logic  cd_v   [CORDIC_STAGES+1];
  logic  cd_rdy [CORDIC_STAGES+1];
  logic [ROLL_W-1:0]  roll_deg;
  logic [PITCH_W-1:0] pitch_deg;
  sqrt_t last_sq;

  ata_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      (s_tdata[AXIS_W-1:0]),
    .in_y      (s_tdata[2*AXIS_W-1:AXIS_W]),
    .in_z      (s_tdata[3*AXIS_W-1:2*AXIS_W]),
    .out_valid (sq_v[0]),
    .out_ready (sq_rdy[0]),
    .out_data  (prep_data)
  );

  always_comb begin
    sq_d[0].s    = prep_data.s;
    sq_d[0].rad  = {prep_data.sumsq, (RAD_W-SUM_W)'(0)};
    sq_d[0].rem  = '0;
    sq_d[0].root = '0;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    ata_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_rdy[k]),
      .in_data   (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_data  (sq_d[k+1])
    );
  end

  // load both cordic lanes; a zero operand overrides the rotation result
  always_comb begin
    last_sq = sq_d[SQRT_STEPS];
    cd_d[0].roll.xv  = {4'b0, last_sq.s.mag_z, 16'b0};
    cd_d[0].roll.yv  = {4'b0, last_sq.s.mag_y, 16'b0};
    cd_d[0].roll.ang = '0;
    if (last_sq.s.mag_y == '0) begin
      cd_d[0].roll.spc = SPC_ZERO;
    end else if (last_sq.s.mag_z == '0) begin
      cd_d[0].roll.spc = SPC_RIGHT;
    end else begin
      cd_d[0].roll.spc = SPC_NONE;
    end
    cd_d[0].pitch.xv  = {4'b0, last_sq.root, 8'b0};
    cd_d[0].pitch.yv  = {4'b0, last_sq.s.mag_x, 16'b0};
    cd_d[0].pitch.ang = '0;
    if (last_sq.s.mag_x == '0) begin
      cd_d[0].pitch.spc = SPC_ZERO;
    end else if (last_sq.root == '0) begin
      cd_d[0].pitch.spc = SPC_RIGHT;
    end else begin
      cd_d[0].pitch.spc = SPC_NONE;
    end
    cd_d[0].x_pos = last_sq.s.x_pos;
    cd_d[0].y_neg = last_sq.s.y_neg;
    cd_d[0].z_neg = last_sq.s.z_neg;
  end

  assign cd_v[0]            = sq_v[SQRT_STEPS];
  assign sq_rdy[SQRT_STEPS] = cd_rdy[0];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    ata_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cd_v[i]),
      .in_ready  (cd_rdy[i]),
      .in_data   (cd_d[i]),
      .out_valid (cd_v[i+1]),
      .out_ready (cd_rdy[i+1]),
      .out_data  (cd_d[i+1])
    );
  end

  ata_finish #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cd_v[CORDIC_STAGES]),
    .in_ready  (cd_rdy[CORDIC_STAGES]),
    .in_data   (cd_d[CORDIC_STAGES]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .roll_deg  (roll_deg),
    .pitch_deg (pitch_deg)
  );

  assign m_tdata = {(M_TDATA_W-ROLL_W-PITCH_W)'(0), pitch_deg, roll_deg};

  // square root remainder stays below 2*root + 1
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sq_v[SQRT_STEPS] |-> last_sq.rem <= {1'b0, last_sq.root, 1'b0})
    else $error("square root remainder out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(roll_deg) <= ROLL_MAX) && ($signed(roll_deg) >= -ROLL_MAX))
    else $error("roll beyond half turn");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(pitch_deg) <= PITCH_MAX) && ($signed(pitch_deg) >= -PITCH_MAX))
    else $error("pitch beyond right angle");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> sq_v[0])
    else $error("accepted beat missing from first cell");

endmodule

`default_nettype wire
